@@ sv/lrfc_pkg.sv @@
package lrfc_pkg;

  // Record header layout and op codes
  localparam logic [7:0] OP_SET = 8'h01;
  localparam logic [7:0] OP_DEL = 8'h02;
  localparam logic [3:0] HDR_LAST = 4'd15;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_KEY   = 2'd0;
  localparam logic [1:0] CFG_MAX_VALUE = 2'd1;
  localparam logic [31:0] MAX_KEY_RESET   = 32'd4096;
  localparam logic [31:0] MAX_VALUE_RESET = 32'd65536;

  // Result kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Record status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_OP   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE = 3'd2;
  localparam logic [2:0] ST_BAD_CRC  = 3'd3;
  localparam logic [2:0] ST_EOL      = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  // Result queue geometry
  localparam int unsigned LRFC_DEPTH = 8;
  localparam int unsigned LRFC_PTR_W = $clog2(LRFC_DEPTH);
  localparam int unsigned LRFC_LVL_W = $clog2(LRFC_DEPTH + 1);

  // Frame phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_KEY    = 4'b0010,
    PH_VALUE  = 4'b0100,
    PH_HALT   = 4'b1000
  } phase_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic [2:0]  status;
    logic        is_del;
    logic [31:0] ksize;
    logic [31:0] vsize;
    logic        last;
  } result_t;

  // Results produced by one input transaction
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  // One byte through the reflected CRC-32, bit at a time
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ sv/log_record_frame_checker.sv @@
// Channel   | Direction | Handshake              | Payload
// input     | in        | in_valid / in_stall    | stream_byte, stream_end
// result    | out       | out_valid / out_stall  | result_kind, payload_byte, status,
//           |           |                        | is_delete, key_size, value_size, last_of_input
// config    | in        | cfg_write              | cfg_index, cfg_data
//
// One input byte per cycle while in_stall is low; a transaction is decoded in the cycle
// after it is taken and its results reach out_valid the cycle after that.
// Results go through an 8-entry queue, one result transaction per cycle unless out_stall holds
// it; the record's last payload byte makes two results, so output drains set the rate.
// in_stall rises when the queue could not hold two results for each byte in flight.
// Synchronous reset returns to the header phase with both size limits at defaults.
module log_record_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  status,
  output logic        is_delete,
  output logic [31:0] key_size,
  output logic [31:0] value_size,
  output logic        last_of_input,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lrfc_pkg::*;

  logic                  pend;
  logic                  in_take;
  logic                  pop;
  push_t                 push;
  result_t               head;
  logic [LRFC_LVL_W-1:0] level;
  logic [LRFC_LVL_W:0]   committed;

  // Room check: two slots for the byte in flight and two for a new one
  assign committed = {1'b0, level} + (pend ? (LRFC_LVL_W+1)'(2) : '0);
  assign in_stall  = committed > (LRFC_LVL_W+1)'(LRFC_DEPTH - 2);
  assign in_take   = in_valid && !in_stall;

  lrfc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_take     (in_take),
    .stream_byte (stream_byte),
    .stream_end  (stream_end),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pend        (pend),
    .push        (push)
  );

  assign out_valid = level != '0;
  assign pop       = out_valid && !out_stall;

  lrfc_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .level (level),
    .head  (head)
  );

  // Result fields from the queue head
  assign result_kind   = head.kind;
  assign payload_byte  = head.pbyte;
  assign status        = head.status;
  assign is_delete     = head.is_del;
  assign key_size      = head.ksize;
  assign value_size    = head.vsize;
  assign last_of_input = head.last;

endmodule

@@ sv/lrfc_core.sv @@
module lrfc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_take,
  input  logic [7:0]           stream_byte,
  input  logic                 stream_end,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 pend,
  output lrfc_pkg::push_t      push
);
  import lrfc_pkg::*;

  // Input register
  logic [7:0]  in_byte;
  logic        in_end;

  // Limits
  logic [31:0] max_key_size;
  logic [31:0] max_value_size;

  // Frame state
  phase_t      phase, phase_next;
  logic [3:0]  header_index, header_index_next;
  logic [7:0]  op_byte, op_byte_next;
  logic [31:0] stored_crc, stored_crc_next;
  logic [31:0] key_length, key_length_next;
  logic [31:0] value_length, value_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] running_crc, running_crc_next;

  logic [31:0] crc_upd;
  logic [31:0] left_dec;
  logic [2:0]  hdr_status;
  logic        is_del_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= in_take;
    end
    if (in_take) begin
      in_byte <= stream_byte;
      in_end  <= stream_end;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_key_size   <= MAX_KEY_RESET;
      max_value_size <= MAX_VALUE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_KEY:   max_key_size   <= cfg_data;
        CFG_MAX_VALUE: max_value_size <= cfg_data;
        default: ;
      endcase
    end
  end

  assign crc_upd  = crc_byte(running_crc, in_byte);
  assign left_dec = bytes_left - 32'd1;

  // Frame decode for the registered transaction
  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    op_byte_next      = op_byte;
    stored_crc_next   = stored_crc;
    key_length_next   = key_length;
    value_length_next = value_length;
    bytes_left_next   = bytes_left;
    running_crc_next  = running_crc;
    push              = '0;
    hdr_status        = ST_OK;
    is_del_n          = 1'b0;

    if (pend && phase != PH_HALT) begin
      if (in_end) begin
        push.count     = 2'd1;
        push.r0.kind   = KIND_STATUS;
        push.r0.last   = 1'b1;
        if (phase == PH_HEADER) begin
          if (header_index == 4'd0) begin
            push.r0.status = ST_EOL;
          end else begin
            push.r0.status = ST_TRUNC;
            phase_next     = PH_HALT;
          end
        end else begin
          push.r0.status = ST_TRUNC;
          push.r0.is_del = (op_byte == OP_DEL);
          push.r0.ksize  = key_length;
          push.r0.vsize  = value_length;
          phase_next     = PH_HALT;
        end
      end else if (phase == PH_HEADER) begin
        // Capture header byte into its lane
        case (header_index[3:2])
          2'd0: begin
            if (header_index[1:0] == 2'd0) begin
              op_byte_next      = in_byte;
              stored_crc_next   = '0;
              key_length_next   = '0;
              value_length_next = '0;
            end
          end
          2'd1: stored_crc_next[8*header_index[1:0] +: 8] = in_byte;
          2'd2: key_length_next[8*header_index[1:0] +: 8] = in_byte;
          2'd3: value_length_next[8*header_index[1:0] +: 8] = in_byte;
          default: ;
        endcase
        header_index_next = header_index + 4'd1;

        if (header_index == HDR_LAST) begin
          is_del_n = (op_byte_next == OP_DEL);
          // Op first, then limits, then a delete carrying a value
          if (op_byte_next != OP_SET && op_byte_next != OP_DEL) begin
            hdr_status = ST_BAD_OP;
          end else if (key_length_next > max_key_size ||
                       value_length_next > max_value_size) begin
            hdr_status = ST_BAD_SIZE;
          end else if (is_del_n && value_length_next != 32'd0) begin
            hdr_status = ST_BAD_SIZE;
          end

          push.r0.kind   = KIND_STATUS;
          push.r0.is_del = is_del_n;
          push.r0.ksize  = key_length_next;
          push.r0.vsize  = value_length_next;
          push.r0.last   = 1'b1;

          if (hdr_status != ST_OK) begin
            push.count     = 2'd1;
            push.r0.status = hdr_status;
            phase_next     = PH_HALT;
          end else begin
            running_crc_next = CRC_INIT;
            if (key_length_next != 32'd0) begin
              phase_next      = PH_KEY;
              bytes_left_next = key_length_next;
            end else if (value_length_next != 32'd0) begin
              phase_next      = PH_VALUE;
              bytes_left_next = value_length_next;
            end else begin
              // Empty record: CRC of nothing is zero
              push.count     = 2'd1;
              push.r0.status = (stored_crc_next == 32'd0) ? ST_OK : ST_BAD_CRC;
            end
          end
        end
      end else begin
        // Key or value byte passes through
        push.count     = 2'd1;
        push.r0.kind   = (phase == PH_KEY) ? KIND_KEY : KIND_VALUE;
        push.r0.pbyte  = in_byte;
        push.r0.is_del = (op_byte == OP_DEL);
        push.r0.ksize  = key_length;
        push.r0.vsize  = value_length;
        push.r0.last   = 1'b1;
        running_crc_next = crc_upd;
        bytes_left_next  = left_dec;
        if (left_dec == 32'd0) begin
          if (phase == PH_KEY && value_length != 32'd0) begin
            phase_next      = PH_VALUE;
            bytes_left_next = value_length;
          end else begin
            push.count     = 2'd2;
            push.r0.last   = 1'b0;
            push.r1        = push.r0;
            push.r1.kind   = KIND_STATUS;
            push.r1.pbyte  = 8'd0;
            push.r1.status = ((~crc_upd) == stored_crc) ? ST_OK : ST_BAD_CRC;
            push.r1.last   = 1'b1;
            phase_next     = PH_HEADER;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_index <= '0;
      op_byte      <= '0;
      stored_crc   <= '0;
      key_length   <= '0;
      value_length <= '0;
      bytes_left   <= '0;
      running_crc  <= CRC_INIT;
    end else begin
      phase        <= phase_next;
      header_index <= header_index_next;
      op_byte      <= op_byte_next;
      stored_crc   <= stored_crc_next;
      key_length   <= key_length_next;
      value_length <= value_length_next;
      bytes_left   <= bytes_left_next;
      running_crc  <= running_crc_next;
    end
  end

endmodule

@@ sv/lrfc_result_fifo.sv @@
module lrfc_result_fifo (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lrfc_pkg::push_t                      push,
  input  logic                                 pop,
  output logic [lrfc_pkg::LRFC_LVL_W-1:0]      level,
  output lrfc_pkg::result_t                    head
);
  import lrfc_pkg::*;

  result_t mem [LRFC_DEPTH];
  logic [LRFC_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LRFC_PTR_W-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr + 1'b1;
  assign head    = mem[rd_ptr];

  // Storage: up to two writes per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + LRFC_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + LRFC_LVL_W'(push.count) - LRFC_LVL_W'(pop);
    end
  end

endmodule

@@ sv/lrfc_checker.sv @@
module lrfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  result_kind,
  input logic [7:0]  payload_byte,
  input logic [2:0]  status,
  input logic        last_of_input
);
  import lrfc_pkg::*;

  // A held result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Byte results carry no status; status results carry no byte
  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_STATUS |-> status == ST_OK)
    else $error("byte result with nonzero status");

  a_status_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_STATUS |-> payload_byte == 8'd0)
    else $error("status result with nonzero byte");

  // A status result always closes its input transaction
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_STATUS |-> last_of_input)
    else $error("status result not marked last");

endmodule

bind log_record_frame_checker lrfc_checker u_lrfc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .result_kind   (result_kind),
  .payload_byte  (payload_byte),
  .status        (status),
  .last_of_input (last_of_input)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import lrfc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Header layout offsets
  localparam logic [3:0] HDR_CRC_AT   = 4'd4;
  localparam logic [3:0] HDR_KEY_AT   = 4'd8;
  localparam logic [3:0] HDR_VALUE_AT = 4'd12;

  // Register indexes that map to nothing
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  localparam int unsigned RANDOM_BYTES = 2000;
  localparam int unsigned MAX_BODY     = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  stream_byte = '0;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic        is_delete;
  logic [31:0] key_size;
  logic [31:0] value_size;
  logic        last_of_input;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Frame tracker state
  phase_t      frame_phase;
  logic [3:0]  hdr_pos;
  logic [7:0]  hdr_op;
  logic [31:0] hdr_crc;
  logic [31:0] hdr_klen;
  logic [31:0] hdr_vlen;
  logic [31:0] body_left;
  logic [31:0] run_crc;
  logic [31:0] key_limit;
  logic [31:0] value_limit;

  result_t     results_due[$];
  int unsigned bytes_taken = 0;
  int unsigned errors = 0;
  bit          steady = 1'b0;

  log_record_frame_checker u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .stream_byte   (stream_byte),
    .stream_end    (stream_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .status        (status),
    .is_delete     (is_delete),
    .key_size      (key_size),
    .value_size    (value_size),
    .last_of_input (last_of_input),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Reflected CRC-32, one data bit per iteration, LSB first
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] data);
    logic [31:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] pb,
                                          input logic [2:0] st, input bit with_hdr);
    result_t r;
    r.kind   = kind;
    r.pbyte  = pb;
    r.status = st;
    r.is_del = with_hdr && (hdr_op == OP_DEL);
    r.ksize  = with_hdr ? hdr_klen : 32'd0;
    r.vsize  = with_hdr ? hdr_vlen : 32'd0;
    r.last   = 1'b0;
    return r;
  endfunction

  // Record end: compare running CRC with the stored one, back to header phase
  function automatic result_t close_record();
    result_t r;
    r = make_result(KIND_STATUS, 8'd0, (~run_crc == hdr_crc) ? ST_OK : ST_BAD_CRC, 1'b1);
    frame_phase = PH_HEADER;
    return r;
  endfunction

  // Advance the frame tracker by one accepted transaction, queue its results
  task automatic advance_frame(input logic [7:0] b, input logic e);
    result_t    made[$];
    result_t    r;
    logic [2:0] verdict;
    if (frame_phase != PH_HALT) begin
      if (e) begin
        if (frame_phase == PH_HEADER && hdr_pos == 4'd0) begin
          made.push_back(make_result(KIND_STATUS, 8'd0, ST_EOL, 1'b0));
        end else begin
          made.push_back(make_result(KIND_STATUS, 8'd0, ST_TRUNC, frame_phase != PH_HEADER));
          frame_phase = PH_HALT;
        end
      end else if (frame_phase == PH_HEADER) begin
        if (hdr_pos == 4'd0) begin
          hdr_op   = b;
          hdr_crc  = '0;
          hdr_klen = '0;
          hdr_vlen = '0;
        end else if (hdr_pos >= HDR_CRC_AT && hdr_pos < HDR_KEY_AT) begin
          hdr_crc[8*hdr_pos[1:0] +: 8] = b;
        end else if (hdr_pos >= HDR_KEY_AT && hdr_pos < HDR_VALUE_AT) begin
          hdr_klen[8*hdr_pos[1:0] +: 8] = b;
        end else if (hdr_pos >= HDR_VALUE_AT) begin
          hdr_vlen[8*hdr_pos[1:0] +: 8] = b;
        end
        // header complete: op first, then limits, then DEL with a value
        if (hdr_pos == HDR_LAST) begin
          verdict = ST_OK;
          if (hdr_op != OP_SET && hdr_op != OP_DEL) verdict = ST_BAD_OP;
          else if (hdr_klen > key_limit || hdr_vlen > value_limit) verdict = ST_BAD_SIZE;
          else if (hdr_op == OP_DEL && hdr_vlen != 0) verdict = ST_BAD_SIZE;
          if (verdict != ST_OK) begin
            made.push_back(make_result(KIND_STATUS, 8'd0, verdict, 1'b1));
            frame_phase = PH_HALT;
          end else begin
            run_crc = CRC_INIT;
            if (hdr_klen != 0) begin
              frame_phase = PH_KEY;
              body_left = hdr_klen;
            end else if (hdr_vlen != 0) begin
              frame_phase = PH_VALUE;
              body_left = hdr_vlen;
            end else begin
              made.push_back(close_record());
            end
          end
        end
        hdr_pos = hdr_pos + 4'd1;
      end else begin
        // key or value byte passes through
        made.push_back(make_result((frame_phase == PH_KEY) ? KIND_KEY : KIND_VALUE, b, ST_OK,
                                   1'b1));
        run_crc = crc32_step(run_crc, b);
        body_left = body_left - 32'd1;
        if (body_left == 0) begin
          if (frame_phase == PH_KEY && hdr_vlen != 0) begin
            frame_phase = PH_VALUE;
            body_left = hdr_vlen;
          end else begin
            made.push_back(close_record());
          end
        end
      end
    end
    foreach (made[i]) begin
      r = made[i];
      r.last = (i == made.size() - 1);
      results_due.push_back(r);
    end
  endtask

  // Send one transaction; inputs change on the falling edge
  task automatic send_item(input logic [7:0] b, input logic e);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    stream_end  <= e;
    do @(posedge clk); while (in_stall);
    advance_frame(b, e);
    bytes_taken++;
  endtask

  // Hold the input idle until every queued result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_limit(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_MAX_KEY) key_limit = value;
    else if (idx == CFG_MAX_VALUE) value_limit = value;
  endtask

  function automatic byte_q_t header_bytes(input logic [7:0] op, input logic [31:0] crc,
                                           input logic [31:0] klen, input logic [31:0] vlen);
    byte_q_t     hdr;
    logic [95:0] words;
    hdr.push_back(op);
    repeat (3) hdr.push_back(8'($urandom));
    words = {vlen, klen, crc};
    for (int i = 0; i < 12; i++) hdr.push_back(words[8*i +: 8]);
    return hdr;
  endfunction

  function automatic byte_q_t random_body(input int unsigned n);
    byte_q_t body;
    repeat (n) body.push_back(8'($urandom));
    return body;
  endfunction

  function automatic logic [31:0] body_crc(input byte_q_t body);
    logic [31:0] c;
    c = CRC_INIT;
    foreach (body[i]) c = crc32_step(c, body[i]);
    return ~c;
  endfunction

  // Whole record: header with a correct or damaged CRC, then key and value bytes
  task automatic send_record(input logic [7:0] op, input byte_q_t body, input int unsigned klen,
                             input bit corrupt);
    logic [31:0] crc;
    byte_q_t     hdr;
    crc = body_crc(body);
    if (corrupt) crc[$urandom_range(0, 31)] ^= 1'b1;
    hdr = header_bytes(op, crc, klen, body.size() - klen);
    foreach (hdr[i]) send_item(hdr[i], 1'b0);
    foreach (body[i]) send_item(body[i], 1'b0);
  endtask

  task automatic test_end_of_log();
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
  endtask

  // Empty records: status right after the header, CRC of nothing is zero
  task automatic test_empty_records();
    byte_q_t body;
    body = {};
    send_record(OP_SET, body, 0, 1'b0);
    send_record(OP_DEL, body, 0, 1'b1);
  endtask

  task automatic test_payload_records();
    byte_q_t body;
    body = {8'h00, 8'hFF};
    send_record(OP_SET, body, 1, 1'b0);
    body = {8'hFF, 8'h00};
    send_record(OP_DEL, body, 2, 1'b0);
    body = {8'h5A, 8'hA5, 8'hFF};
    send_record(OP_SET, body, 0, 1'b1);
  endtask

  // Limits at zero, at the exact record size, and at all ones
  task automatic test_size_limits();
    byte_q_t body;
    wait_drained();
    set_limit(CFG_MAX_KEY, 32'd0);
    set_limit(CFG_MAX_VALUE, 32'd0);
    body = {};
    send_record(OP_SET, body, 0, 1'b0);
    wait_drained();
    set_limit(CFG_MAX_KEY, 32'd3);
    set_limit(CFG_MAX_VALUE, 32'd2);
    set_limit(CFG_SPARE_LO, 32'($urandom));
    set_limit(CFG_SPARE_HI, 32'($urandom));
    send_record(OP_SET, random_body(5), 3, 1'b0);
    send_record(OP_DEL, random_body(3), 3, 1'b0);
    wait_drained();
    set_limit(CFG_MAX_KEY, 32'hFFFF_FFFF);
    set_limit(CFG_MAX_VALUE, 32'hFFFF_FFFF);
    send_record(OP_SET, random_body(2), 1, 1'b0);
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(1, 16));
    endcase
  endfunction

  // Mostly well-formed records, some bad CRCs, end-of-log marks, drains and limit changes
  task automatic test_random_stream();
    int unsigned goal;
    int unsigned roll;
    int unsigned klen;
    int unsigned vlen;
    logic [7:0]  op;
    goal = bytes_taken + RANDOM_BYTES;
    while (bytes_taken < goal) begin
      steady = (bytes_taken + 1300 > goal) && (bytes_taken + 1000 < goal);
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_item(8'($urandom), 1'b1);
      end else if (roll < 7) begin
        wait_drained();
      end else if (roll < 9) begin
        wait_drained();
        set_limit($urandom_range(0, 1) ? CFG_MAX_VALUE : CFG_MAX_KEY, pick_limit());
      end else begin
        op = $urandom_range(0, 1) ? OP_DEL : OP_SET;
        klen = $urandom_range(0, (key_limit < MAX_BODY) ? key_limit : MAX_BODY);
        vlen = (op == OP_DEL) ? 0 :
               $urandom_range(0, (value_limit < MAX_BODY) ? value_limit : MAX_BODY);
        send_record(op, random_body(klen + vlen), klen, $urandom_range(0, 99) < 15);
      end
    end
    steady = 1'b0;
  endtask

  // One stopping condition per run, then inputs that the stopped block ignores
  task automatic test_halt();
    logic [7:0]  op;
    logic [31:0] lim;
    int unsigned klen;
    int unsigned vlen;
    int unsigned cut;
    byte_q_t     hdr;
    byte_q_t     body;
    wait_drained();
    set_limit(CFG_MAX_KEY, 32'd16);
    set_limit(CFG_MAX_VALUE, 32'd16);
    case ($urandom_range(0, 5))
      0: begin
        do op = 8'($urandom); while (op == OP_SET || op == OP_DEL);
        hdr = header_bytes(op, $urandom, $urandom, $urandom);
        foreach (hdr[i]) send_item(hdr[i], 1'b0);
      end
      1: begin
        lim = $urandom_range(0, 32'hFFFF_FFFE);
        set_limit(CFG_MAX_KEY, lim);
        hdr = header_bytes(OP_SET, $urandom, $urandom_range(lim + 1, 32'hFFFF_FFFF),
                           $urandom_range(0, 16));
        foreach (hdr[i]) send_item(hdr[i], 1'b0);
      end
      2: begin
        lim = $urandom_range(0, 32'hFFFF_FFFE);
        set_limit(CFG_MAX_VALUE, lim);
        hdr = header_bytes(OP_SET, $urandom, $urandom_range(0, 16),
                           $urandom_range(lim + 1, 32'hFFFF_FFFF));
        foreach (hdr[i]) send_item(hdr[i], 1'b0);
      end
      3: begin
        hdr = header_bytes(OP_DEL, $urandom, $urandom_range(0, 16),
                           $urandom_range(1, 32'hFFFF_FFFF));
        foreach (hdr[i]) send_item(hdr[i], 1'b0);
      end
      4: begin
        hdr = header_bytes(OP_SET, $urandom, 32'd0, 32'd0);
        cut = $urandom_range(1, 15);
        for (int i = 0; i < cut; i++) send_item(hdr[i], 1'b0);
        send_item(8'($urandom), 1'b1);
      end
      default: begin
        klen = $urandom_range(0, 16);
        vlen = $urandom_range(1, 16);
        body = random_body(klen + vlen);
        hdr = header_bytes(OP_SET, body_crc(body), klen, vlen);
        foreach (hdr[i]) send_item(hdr[i], 1'b0);
        cut = $urandom_range(0, klen + vlen - 1);
        for (int i = 0; i < cut; i++) send_item(body[i], 1'b0);
        send_item(8'($urandom), 1'b1);
      end
    endcase
    repeat (10) send_item(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Main sequence
  initial begin
    frame_phase = PH_HEADER;
    hdr_pos     = '0;
    hdr_op      = '0;
    hdr_crc     = '0;
    hdr_klen    = '0;
    hdr_vlen    = '0;
    body_left   = '0;
    run_crc     = CRC_INIT;
    key_limit   = MAX_KEY_RESET;
    value_limit = MAX_VALUE_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_end_of_log();
    test_empty_records();
    test_payload_records();
    test_size_limits();
    test_random_stream();
    test_halt();
    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver stalls at random, except during the steady stretch
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 30);
  end

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  // Compare each result transaction with the oldest one due
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result: kind %0d byte 0x%0h status %0d", $time,
                 result_kind, payload_byte, status);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(result_kind));
        check_field("payload_byte", 32'(want.pbyte), 32'(payload_byte));
        check_field("status", 32'(want.status), 32'(status));
        check_field("is_delete", 32'(want.is_del), 32'(is_delete));
        check_field("key_size", want.ksize, key_size);
        check_field("value_size", want.vsize, value_size);
        check_field("last_of_input", 32'(want.last), 32'(last_of_input));
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
sv/lrfc_pkg.sv
sv/lrfc_core.sv
sv/lrfc_result_fifo.sv
sv/log_record_frame_checker.sv
sv/lrfc_checker.sv
tb/sv/testbench.sv
